// ===== sv/axrot_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table for the axis-angle rotation block.
// No dependencies.
package axrot_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int AW               = 14;   // reduced angle, Q8.6 within +/-90 deg
    localparam int XW               = 34;   // CORDIC datapath, Q2.30 with headroom
    localparam int PW               = 67;   // Q58 entry accumulator

    localparam logic signed [16:0] DEG_FULL_TURN    = 17'sd23040;
    localparam logic signed [16:0] DEG_HALF_TURN    = 17'sd11520;
    localparam logic signed [16:0] DEG_QUARTER_TURN = 17'sd5760;

    localparam logic signed [49:0] RAD_PER_DEG_Q40 = 50'sd19190098069;
    localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [XW-1:0] ONE_Q30         = 34'sd1073741824;
    localparam logic [31:0]          ONE_Q24         = 32'd16777216;

    typedef logic signed [XW-1:0] cval_t;
    typedef logic signed [PW-1:0] acc_t;

    function automatic cval_t atan_q30(input int idx);
        cval_t r;
        case (idx)
            0:       r = 34'sd843314857;
            1:       r = 34'sd497837829;
            2:       r = 34'sd263043837;
            3:       r = 34'sd133525159;
            4:       r = 34'sd67021687;
            5:       r = 34'sd33543516;
            6:       r = 34'sd16775851;
            7:       r = 34'sd8388437;
            8:       r = 34'sd4194283;
            9:       r = 34'sd2097149;
            10:      r = 34'sd1048576;
            11:      r = 34'sd524288;
            12:      r = 34'sd262144;
            13:      r = 34'sd131072;
            14:      r = 34'sd65536;
            15:      r = 34'sd32768;
            16:      r = 34'sd16384;
            17:      r = 34'sd8192;
            18:      r = 34'sd4096;
            19:      r = 34'sd2048;
            20:      r = 34'sd1024;
            21:      r = 34'sd512;
            22:      r = 34'sd256;
            23:      r = 34'sd128;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Round half up from Q58 to Q24 and keep the low 32 bits.
    function automatic logic [31:0] to_q24(input acc_t v);
        acc_t t;
        t = v + (acc_t'(1) <<< 33);
        return t[65:34];
    endfunction

endpackage

// ===== sv/axis_angle_rotation_matrix_top.sv =====
`timescale 1ns / 1ps
// Requests are pipelined; throughput is limited by the four-column output serializer.
// A request is accepted while stage C is empty or the serializer can take its matrix.
// Each request gives four columns (0..3), tlast on column 3. Pipeline stalls as a
// whole when stage C holds a matrix and the serializer is still busy; nothing is lost or repeated.
// Reset (rst_n, async, active low) clears all valid bits; items are independent.
// Depends on axrot_pkg.
module axis_angle_rotation_matrix_top #(
    parameter int CORDIC_STEPS = axrot_pkg::CORDIC_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // angle_deg[15:0], axis_x[31:16], axis_y[47:32], axis_z[63:48]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // row0_entry[31:0], row1_entry[63:32], row2_entry[95:64], row3_entry[127:96]
    output logic [1:0]   m_tuser,   // column_index[1:0]
    output logic         m_tlast    // last_column
);
    import axrot_pkg::*;

    localparam int N = CORDIC_STEPS;

    // ---------------- pipeline control ----------------
    logic adv;          // whole pipeline moves one stage
    logic ser_free;     // serializer can take a matrix this cycle
    logic pc_vld_reg;

    assign adv      = !pc_vld_reg || ser_free;
    assign s_tready = adv;

    // ---------------- stage 0: angle reduction ----------------
    logic signed [16:0] a_full, m_a, m_b, m_c;
    logic               flip_c;

    always_comb
    begin
        a_full = 17'(signed'(s_tdata[15:0]));
        // truncating modulo by a full turn
        if (a_full >= DEG_FULL_TURN)
            m_a = a_full - DEG_FULL_TURN;
        else if (a_full <= -DEG_FULL_TURN)
            m_a = a_full + DEG_FULL_TURN;
        else
            m_a = a_full;
        // into [-180, 180]
        if (m_a > DEG_HALF_TURN)
            m_b = m_a - DEG_FULL_TURN;
        else if (m_a < -DEG_HALF_TURN)
            m_b = m_a + DEG_FULL_TURN;
        else
            m_b = m_a;
        // fold far half circle into +/-90, flipping the signs of sine and cosine
        flip_c = 1'b0;
        m_c    = m_b;
        if (m_b > DEG_QUARTER_TURN)
        begin
            m_c    = m_b - DEG_HALF_TURN;
            flip_c = 1'b1;
        end
        else if (m_b < -DEG_QUARTER_TURN)
        begin
            m_c    = m_b + DEG_HALF_TURN;
            flip_c = 1'b1;
        end
    end

    logic                 s0_vld_reg;
    logic signed [AW-1:0] s0_ang_reg;
    logic                 s0_flip_reg;
    logic [47:0]          s0_axis_reg;

    // ---------------- CORDIC stages ----------------
    // index 0 holds the start vector and radians, index k the result of iteration k-1
    logic        cv_reg   [0:N];
    cval_t       cx_reg   [0:N];
    cval_t       cy_reg   [0:N];
    cval_t       cz_reg   [0:N];
    logic        cf_reg   [0:N];
    logic [47:0] cax_reg  [0:N];

    logic signed [49:0] rad_prod;
    logic signed [49:0] rad_rnd;

    assign rad_prod = 50'(s0_ang_reg) * RAD_PER_DEG_Q40;
    assign rad_rnd  = rad_prod + 50'sd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            cv_reg[0]  <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg <= s_tvalid;
            cv_reg[0]  <= s0_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_ang_reg  <= AW'(m_c);
            s0_flip_reg <= flip_c;
            s0_axis_reg <= s_tdata[63:16];
            cx_reg[0]   <= CORDIC_GAIN_Q30;
            cy_reg[0]   <= '0;
            cz_reg[0]   <= rad_rnd[49:16];
            cf_reg[0]   <= s0_flip_reg;
            cax_reg[0]  <= s0_axis_reg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cordic
            cval_t dx, dy;
            assign dx = cy_reg[gi] >>> gi;
            assign dy = cx_reg[gi] >>> gi;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    cv_reg[gi+1] <= 1'b0;
                else if (adv)
                    cv_reg[gi+1] <= cv_reg[gi];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (!cz_reg[gi][XW-1])
                    begin
                        cx_reg[gi+1] <= cx_reg[gi] - dx;
                        cy_reg[gi+1] <= cy_reg[gi] + dy;
                        cz_reg[gi+1] <= cz_reg[gi] - atan_q30(gi);
                    end
                    else
                    begin
                        cx_reg[gi+1] <= cx_reg[gi] + dx;
                        cy_reg[gi+1] <= cy_reg[gi] - dy;
                        cz_reg[gi+1] <= cz_reg[gi] + atan_q30(gi);
                    end
                    cf_reg[gi+1]  <= cf_reg[gi];
                    cax_reg[gi+1] <= cax_reg[gi];
                end
            end
        end
    endgenerate

    // ---------------- stage A: sign fix, axis products ----------------
    logic signed [15:0] ax_n, ay_n, az_n;
    assign ax_n = cax_reg[N][15:0];
    assign ay_n = cax_reg[N][31:16];
    assign az_n = cax_reg[N][47:32];

    logic               pa_vld_reg;
    cval_t              pa_c_reg, pa_s_reg;
    logic signed [15:0] pa_x_reg, pa_y_reg, pa_z_reg;
    logic signed [31:0] pa_xx_reg, pa_yy_reg, pa_zz_reg, pa_xy_reg, pa_xz_reg, pa_yz_reg;

    // ---------------- stage B: scale by (1 - c) and by s ----------------
    logic  pb_vld_reg;
    acc_t  pb_xx_reg, pb_yy_reg, pb_zz_reg, pb_xy_reg, pb_xz_reg, pb_yz_reg;
    acc_t  pb_sx_reg, pb_sy_reg, pb_sz_reg, pb_c_reg;
    cval_t omc;

    assign omc = ONE_Q30 - pa_c_reg;

    // ---------------- stage C: sums and rounding ----------------
    logic [31:0] pc_e_reg [0:8];   // ent[col][row], col*3+row for the upper 3x3

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_vld_reg <= 1'b0;
            pb_vld_reg <= 1'b0;
            pc_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            pa_vld_reg <= cv_reg[N];
            pb_vld_reg <= pa_vld_reg;
            pc_vld_reg <= pb_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_c_reg  <= cf_reg[N] ? -cx_reg[N] : cx_reg[N];
            pa_s_reg  <= cf_reg[N] ? -cy_reg[N] : cy_reg[N];
            pa_x_reg  <= ax_n;
            pa_y_reg  <= ay_n;
            pa_z_reg  <= az_n;
            pa_xx_reg <= 32'(ax_n * ax_n);
            pa_yy_reg <= 32'(ay_n * ay_n);
            pa_zz_reg <= 32'(az_n * az_n);
            pa_xy_reg <= 32'(ax_n * ay_n);
            pa_xz_reg <= 32'(ax_n * az_n);
            pa_yz_reg <= 32'(ay_n * az_n);

            pb_xx_reg <= acc_t'(pa_xx_reg) * acc_t'(omc);
            pb_yy_reg <= acc_t'(pa_yy_reg) * acc_t'(omc);
            pb_zz_reg <= acc_t'(pa_zz_reg) * acc_t'(omc);
            pb_xy_reg <= acc_t'(pa_xy_reg) * acc_t'(omc);
            pb_xz_reg <= acc_t'(pa_xz_reg) * acc_t'(omc);
            pb_yz_reg <= acc_t'(pa_yz_reg) * acc_t'(omc);
            pb_sx_reg <= acc_t'(pa_x_reg) * acc_t'(pa_s_reg);
            pb_sy_reg <= acc_t'(pa_y_reg) * acc_t'(pa_s_reg);
            pb_sz_reg <= acc_t'(pa_z_reg) * acc_t'(pa_s_reg);
            pb_c_reg  <= acc_t'(pa_c_reg) <<< 28;

            pc_e_reg[0] <= to_q24(pb_xx_reg + pb_c_reg);
            pc_e_reg[1] <= to_q24(pb_xy_reg + (pb_sz_reg <<< 14));
            pc_e_reg[2] <= to_q24(pb_xz_reg - (pb_sy_reg <<< 14));
            pc_e_reg[3] <= to_q24(pb_xy_reg - (pb_sz_reg <<< 14));
            pc_e_reg[4] <= to_q24(pb_yy_reg + pb_c_reg);
            pc_e_reg[5] <= to_q24(pb_yz_reg + (pb_sx_reg <<< 14));
            pc_e_reg[6] <= to_q24(pb_xz_reg + (pb_sy_reg <<< 14));
            pc_e_reg[7] <= to_q24(pb_yz_reg - (pb_sx_reg <<< 14));
            pc_e_reg[8] <= to_q24(pb_zz_reg + pb_c_reg);
        end
    end

    // ---------------- output serializer: one column per beat ----------------
    logic        ser_vld_reg, ser_vld_next;
    logic [1:0]  col_reg, col_next;
    logic [31:0] ser_e_reg [0:8];

    assign ser_free = !ser_vld_reg || (m_tready && col_reg == 2'd3);

    always_comb
    begin
        ser_vld_next = ser_vld_reg;
        col_next     = col_reg;
        if (ser_free)
        begin
            ser_vld_next = pc_vld_reg;
            col_next     = 2'd0;
        end
        else if (m_tready)
            col_next = col_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_vld_reg <= 1'b0;
            col_reg     <= 2'd0;
        end
        else
        begin
            ser_vld_reg <= ser_vld_next;
            col_reg     <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_free && pc_vld_reg)
            ser_e_reg <= pc_e_reg;
    end

    always_comb
    begin
        case (col_reg)
            2'd0:    m_tdata = {32'd0, ser_e_reg[2], ser_e_reg[1], ser_e_reg[0]};
            2'd1:    m_tdata = {32'd0, ser_e_reg[5], ser_e_reg[4], ser_e_reg[3]};
            2'd2:    m_tdata = {32'd0, ser_e_reg[8], ser_e_reg[7], ser_e_reg[6]};
            default: m_tdata = {ONE_Q24, 32'd0, 32'd0, 32'd0};
        endcase
    end

    assign m_tvalid = ser_vld_reg;
    assign m_tuser  = col_reg;
    assign m_tlast  = (col_reg == 2'd3);

endmodule

// ===== dv/axis_angle_rotation_matrix_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for axis_angle_rotation_matrix_top: streams angle/axis requests,
// predicts the four matrix columns with a local CORDIC model. Depends on axrot_pkg and the DUT.
module axis_angle_rotation_matrix_top_tb;

    localparam int STEPS = 16;

    // one predicted matrix column
    typedef struct packed {
        logic [1:0]  col;
        logic [31:0] r0, r1, r2, r3;
        logic        last;
    } column_t;

    class matrix_scoreboard;
        column_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        static function logic [31:0] q58_to_q24(logic signed [66:0] v);
            logic signed [66:0] t;
            t = v + (67'sd1 <<< 33);
            return t[65:34];
        endfunction

        // Builds the four columns for one accepted request.
        function void note_request(logic [63:0] d);
            longint m, x, y, z, dx, dy, c, s;
            logic signed [66:0] omc, cq, sx, sy, sz, xx, yy, zz, xy, xz, yz;
            logic signed [66:0] ax, ay, az;
            logic [31:0] e [4][4];
            longint atn [24];
            bit flip;
            column_t cl;
            atn = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
            m = longint'($signed(d[15:0])) % 23040;
            flip = 0;
            if (m > 11520) m -= 23040;
            if (m < -11520) m += 23040;
            if (m > 5760) begin m -= 11520; flip = 1; end
            if (m < -5760) begin m += 11520; flip = 1; end
            z = (m * 64'sd19190098069 + (64'sd1 << 15)) >>> 16;
            x = 652032874;
            y = 0;
            for (int i = 0; i < STEPS && i < 24; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= atn[i];
                end
                else
                begin
                    x += dx; y -= dy; z += atn[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
            ax = $signed(d[31:16]);
            ay = $signed(d[47:32]);
            az = $signed(d[63:48]);
            omc = 67'sd1073741824 - 67'(c);
            cq = 67'(c) <<< 28;
            sx = (ax * 67'(s)) <<< 14;
            sy = (ay * 67'(s)) <<< 14;
            sz = (az * 67'(s)) <<< 14;
            xx = ax * ax * omc; yy = ay * ay * omc; zz = az * az * omc;
            xy = ax * ay * omc; xz = ax * az * omc; yz = ay * az * omc;
            e[0][0] = q58_to_q24(xx + cq);
            e[0][1] = q58_to_q24(xy + sz);
            e[0][2] = q58_to_q24(xz - sy);
            e[1][0] = q58_to_q24(xy - sz);
            e[1][1] = q58_to_q24(yy + cq);
            e[1][2] = q58_to_q24(yz + sx);
            e[2][0] = q58_to_q24(xz + sy);
            e[2][1] = q58_to_q24(yz - sx);
            e[2][2] = q58_to_q24(zz + cq);
            for (int k = 0; k < 3; k++)
            begin
                e[k][3] = '0;
                e[3][k] = '0;
            end
            e[3][3] = axrot_pkg::ONE_Q24;
            for (int k = 0; k < 4; k++)
            begin
                cl.col = k[1:0];
                cl.r0 = e[k][0]; cl.r1 = e[k][1]; cl.r2 = e[k][2]; cl.r3 = e[k][3];
                cl.last = (k == 3);
                pending.push_back(cl);
            end
        endfunction

        function void check_column(logic [127:0] d, logic [1:0] u, logic l);
            column_t got, want;
            got = {u, d[31:0], d[63:32], d[95:64], d[127:96], l};
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected column %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10) $display("column mismatch: exp %h got %h", want, got);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [63:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [127:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;

    matrix_scoreboard sb = new();
    longint cycles = 0;

    always #5 clk = ~clk;

    axis_angle_rotation_matrix_top #(.CORDIC_STEPS(STEPS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // cycle limit for the whole run, with margin for request gaps and receiver stalls
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("[axis_angle_rotation_matrix_top] ERROR");
            $finish;
        end
    end

    // sample on the edge; predictions and checks happen in handshake order
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready) sb.note_request(s_tdata);
        if (rst_n && m_tvalid && m_tready) sb.check_column(m_tdata, m_tuser, m_tlast);
    end

    // receiver: random stall before each column, with stall-free stretches
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (w > 0)
            begin
                m_tready <= 0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic send_request(logic [15:0] ang, logic [15:0] x, logic [15:0] y,
                                logic [15:0] z, int gap);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {z, y, x, ang};
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h4000;  // unit axis
            3: return 16'hc000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int wait_n;
        logic [15:0] angs [12];
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: angle extremes, quadrant edges, fold boundaries, axis extremes
        angs = '{16'h0000, 16'h7fff, 16'h8000, 16'd5760, -16'd5760, 16'd5761,
                 16'd11520, -16'd11520, 16'd23040, -16'd23040, 16'd11521, 16'd17280};
        foreach (angs[i])
            send_request(angs[i], 16'h4000, 16'h0000, 16'h0000, 0);
        send_request(16'd2880, 16'h0000, 16'h4000, 16'h0000, 1);
        send_request(16'd2880, 16'h0000, 16'h0000, 16'h4000, 0);
        send_request(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 3);
        send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        send_request(16'h1234, 16'h8000, 16'h7fff, 16'h0000, 0);  // unnormalized axis
        send_request(16'hffff, 16'hffff, 16'hffff, 16'hffff, 2);
        send_request(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0);
        send_request(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 0);
        for (int n = 0; n < 450; n++)
        begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            send_request(rand_field(), rand_field(), rand_field(), rand_field(), wait_n);
        end
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (STEPS + 40) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[axis_angle_rotation_matrix_top] OK");
        else
            $display("[axis_angle_rotation_matrix_top] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/axrot_pkg.sv
sv/axis_angle_rotation_matrix_top.sv
dv/axis_angle_rotation_matrix_top_tb.sv
